@@ rtl/core/salru_pkg.sv @@
// ----------------------------------------------------------------------------
// salru_pkg
// Shared constants, register indexes and result type of the LRU tag simulator.
// ----------------------------------------------------------------------------
package salru_pkg;

    localparam int MAX_SETS_DEF   = 64;
    localparam int MAX_WAYS_DEF   = 8;
    localparam int ADDR_WIDTH_DEF = 32;

    localparam int CNT_W        = 32;
    localparam int STAMP_W      = 32;
    localparam int SET_BITS_W   = 3;
    localparam int WAYS_W       = 4;
    localparam int BLOCK_BITS_W = 5;
    localparam int CFG_DATA_W   = 5;
    localparam int CFG_IDX_W    = 2;
    localparam int TSHIFT_W     = 6;

    localparam int MID_DEPTH = 2;
    localparam int OUT_DEPTH = 2;

    localparam logic [STAMP_W-1:0] STAMP_INIT = 32'h7fff_ffff;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SET_BITS,
        REG_WAYS,
        REG_BLOCK_BITS
    } cfg_reg_t;

    typedef struct packed {
        logic             hit;
        logic             miss;
        logic             evicted;
        logic [CNT_W-1:0] hit_total;
        logic [CNT_W-1:0] miss_total;
        logic [CNT_W-1:0] evict_total;
    } result_t;

endpackage

@@ rtl/core/salru_ram.sv @@
// ----------------------------------------------------------------------------
// salru_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module salru_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/core/salru_fifo.sv @@
// ----------------------------------------------------------------------------
// salru_fifo
// Small register queue with push/full and pop/empty sides.
// ----------------------------------------------------------------------------
module salru_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2,
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CW = $clog2(DEPTH + 1)
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    rd_ptr_reg;
    logic [CW-1:0]    count_reg;
    logic             do_push;
    logic             do_pop;

    assign empty   = (count_reg == '0);
    assign full    = (count_reg == CW'(DEPTH));
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

@@ rtl/core/salru_front.sv @@
// ----------------------------------------------------------------------------
// salru_front
// Configuration registers and address split into set index and tag.
// ----------------------------------------------------------------------------
module salru_front import salru_pkg::*; #(
    parameter int MAX_SETS   = MAX_SETS_DEF,
    parameter int MAX_WAYS   = MAX_WAYS_DEF,
    parameter int ADDR_WIDTH = ADDR_WIDTH_DEF,
    localparam int SET_W = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1,
    localparam int EW    = $clog2(MAX_WAYS + 1)
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  logic [ADDR_WIDTH-1:0] address,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  q_full,
    output logic                  q_push,
    output logic [SET_W-1:0]      q_set,
    output logic [ADDR_WIDTH-1:0] q_tag,
    output logic [EW-1:0]         ways_use
);

    localparam int SMAX = $clog2(MAX_SETS + 1) - 1;

    logic [SET_BITS_W-1:0]   set_bits_reg;
    logic [WAYS_W-1:0]       ways_reg;
    logic [BLOCK_BITS_W-1:0] block_bits_reg;
    logic [SET_BITS_W-1:0]   s_use;
    logic [TSHIFT_W-1:0]     tshift;
    logic [ADDR_WIDTH-1:0]   shifted;
    logic [SET_W-1:0]        set_mask;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            set_bits_reg   <= '0;
            ways_reg       <= WAYS_W'(1);
            block_bits_reg <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_SET_BITS:   set_bits_reg   <= cfg_data[SET_BITS_W-1:0];
                REG_WAYS:       ways_reg       <= cfg_data[WAYS_W-1:0];
                REG_BLOCK_BITS: block_bits_reg <= cfg_data[BLOCK_BITS_W-1:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        if (ways_reg == '0)
        begin
            ways_use = EW'(1);
        end
        else if (32'(ways_reg) > 32'(MAX_WAYS))
        begin
            ways_use = EW'(MAX_WAYS);
        end
        else
        begin
            ways_use = EW'(ways_reg);
        end
    end

    assign s_use    = (32'(set_bits_reg) > 32'(SMAX)) ? SET_BITS_W'(SMAX) : set_bits_reg;
    assign tshift   = TSHIFT_W'(s_use) + TSHIFT_W'(block_bits_reg);
    assign shifted  = address >> block_bits_reg;
    assign set_mask = SET_W'((32'd1 << s_use) - 32'd1);

    assign q_tag  = address >> tshift;
    assign q_set  = shifted[SET_W-1:0] & set_mask;
    assign q_push = push && !q_full;

endmodule

@@ rtl/core/salru_back.sv @@
// ----------------------------------------------------------------------------
// salru_back
// Set lookup, LRU victim choice, write-back of the set row and counters.
// ----------------------------------------------------------------------------
module salru_back import salru_pkg::*; #(
    parameter int MAX_SETS   = MAX_SETS_DEF,
    parameter int MAX_WAYS   = MAX_WAYS_DEF,
    parameter int ADDR_WIDTH = ADDR_WIDTH_DEF,
    localparam int SET_W = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1,
    localparam int WAY_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1,
    localparam int EW    = $clog2(MAX_WAYS + 1)
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  q_empty,
    input  logic [SET_W-1:0]      q_set,
    input  logic [ADDR_WIDTH-1:0] q_tag,
    output logic                  q_pop,
    input  logic [EW-1:0]         ways_use,
    input  logic                  out_full,
    output logic                  out_push,
    output result_t               out_data
);

    localparam int LINE_W = 1 + ADDR_WIDTH + STAMP_W;
    localparam int ROW_W  = MAX_WAYS * LINE_W;
    localparam int P      = 1 << $clog2(MAX_WAYS);

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOK,
        S_PICK
    } state_t;

    state_t                state_reg;
    state_t                state_next;
    logic [SET_W-1:0]      set_reg;
    logic [ADDR_WIDTH-1:0] tag_reg;
    logic [STAMP_W-1:0]    clock_reg;
    logic [CNT_W-1:0]      hits_reg;
    logic [CNT_W-1:0]      misses_reg;
    logic [CNT_W-1:0]      evicts_reg;
    logic [CNT_W-1:0]      hits_next;
    logic [CNT_W-1:0]      misses_next;
    logic [CNT_W-1:0]      evicts_next;
    logic [MAX_SETS-1:0]   rowv_reg;
    logic [MAX_WAYS-1:0]   hitv_reg;
    logic [STAMP_W-1:0]    age_reg [MAX_WAYS];
    logic                  inv_found_reg;
    logic [WAY_W-1:0]      inv_idx_reg;

    logic [ROW_W-1:0]      ram_rdata;
    logic [ROW_W-1:0]      ram_wdata;
    logic                  launch;
    logic                  advance;

    logic                  lv [MAX_WAYS];
    logic [ADDR_WIDTH-1:0] lt [MAX_WAYS];
    logic [STAMP_W-1:0]    lr [MAX_WAYS];
    logic [MAX_WAYS-1:0]   live;
    logic [MAX_WAYS-1:0]   hitv_c;
    logic [STAMP_W-1:0]    age_c [MAX_WAYS];
    logic [STAMP_W-1:0]    clock_dec;
    logic                  inv_found_c;
    logic [WAY_W-1:0]      inv_idx_c;
    logic                  any_hit;
    logic                  evict;
    logic [WAY_W-1:0]      oldest;
    logic [WAY_W-1:0]      victim;

    // Oldest live way by pairwise tree; lower way wins a tie.
    function automatic logic [WAY_W-1:0] pick_oldest(
        input logic [MAX_WAYS-1:0] lv_in,
        input logic [STAMP_W-1:0]  age_in [MAX_WAYS]
    );
        logic               cu [P];
        logic [STAMP_W-1:0] ca [P];
        logic [WAY_W-1:0]   ci [P];
        for (int k = 0; k < P; k++)
        begin
            cu[k] = (k < MAX_WAYS) ? lv_in[k] : 1'b0;
            ca[k] = (k < MAX_WAYS) ? age_in[k] : '0;
            ci[k] = WAY_W'(k);
        end
        for (int step = 1; step < P; step = step * 2)
        begin
            for (int k = 0; k + step < P; k = k + 2 * step)
            begin
                if (cu[k + step] && (!cu[k] || (ca[k + step] > ca[k])))
                begin
                    cu[k] = cu[k + step];
                    ca[k] = ca[k + step];
                    ci[k] = ci[k + step];
                end
            end
        end
        return ci[0];
    endfunction

    salru_ram #(
        .WIDTH (ROW_W),
        .DEPTH (MAX_SETS)
    ) u_ram (
        .clk   (clk),
        .we    (advance),
        .waddr (set_reg),
        .wdata (ram_wdata),
        .re    (launch),
        .raddr (q_set),
        .rdata (ram_rdata)
    );

    // Row never written reads as reset lines.
    always_comb
    begin
        for (int j = 0; j < MAX_WAYS; j++)
        begin
            if (rowv_reg[set_reg])
            begin
                lv[j] = ram_rdata[j * LINE_W + LINE_W - 1];
                lt[j] = ram_rdata[j * LINE_W + STAMP_W +: ADDR_WIDTH];
                lr[j] = ram_rdata[j * LINE_W +: STAMP_W];
            end
            else
            begin
                lv[j] = 1'b0;
                lt[j] = '0;
                lr[j] = STAMP_INIT;
            end
            live[j] = (32'(ways_use) > j);
        end
    end

    assign clock_dec = clock_reg - 1'b1;

    always_comb
    begin
        inv_found_c = 1'b0;
        inv_idx_c   = '0;
        for (int j = MAX_WAYS - 1; j >= 0; j--)
        begin
            hitv_c[j] = live[j] && lv[j] && (lt[j] == tag_reg);
            age_c[j]  = lr[j] - clock_dec;
            if (live[j] && !lv[j])
            begin
                inv_found_c = 1'b1;
                inv_idx_c   = WAY_W'(j);
            end
        end
    end

    assign any_hit = |hitv_reg;
    assign evict   = !any_hit && !inv_found_reg;
    assign oldest  = pick_oldest(live, age_reg);
    assign victim  = inv_found_reg ? inv_idx_reg : oldest;

    always_comb
    begin
        logic                  nv;
        logic [ADDR_WIDTH-1:0] nt;
        logic [STAMP_W-1:0]    nr;
        for (int j = 0; j < MAX_WAYS; j++)
        begin
            nv = lv[j];
            nt = lt[j];
            nr = lr[j];
            if (any_hit)
            begin
                if (hitv_reg[j])
                begin
                    nr = clock_reg;
                end
            end
            else if (WAY_W'(j) == victim)
            begin
                nv = 1'b1;
                nt = tag_reg;
                nr = clock_reg;
            end
            ram_wdata[j * LINE_W +: LINE_W] = {nv, nt, nr};
        end
    end

    assign hits_next   = hits_reg + CNT_W'(any_hit);
    assign misses_next = misses_reg + CNT_W'(!any_hit);
    assign evicts_next = evicts_reg + CNT_W'(evict);

    assign advance = (state_reg == S_PICK) && !out_full;
    assign launch  = !q_empty &&
                     ((state_reg == S_IDLE) || (advance && (q_set != set_reg)));

    assign q_pop    = launch;
    assign out_push = advance;

    always_comb
    begin
        out_data.hit         = any_hit;
        out_data.miss        = !any_hit;
        out_data.evicted     = evict;
        out_data.hit_total   = hits_next;
        out_data.miss_total  = misses_next;
        out_data.evict_total = evicts_next;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (launch)
                begin
                    state_next = S_LOOK;
                end
            end
            S_LOOK:
            begin
                state_next = S_PICK;
            end
            S_PICK:
            begin
                if (advance)
                begin
                    state_next = launch ? S_LOOK : S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            clock_reg  <= STAMP_INIT;
            hits_reg   <= '0;
            misses_reg <= '0;
            evicts_reg <= '0;
            rowv_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_LOOK)
            begin
                clock_reg <= clock_dec;
            end
            if (advance)
            begin
                hits_reg          <= hits_next;
                misses_reg        <= misses_next;
                evicts_reg        <= evicts_next;
                rowv_reg[set_reg] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (launch)
        begin
            set_reg <= q_set;
            tag_reg <= q_tag;
        end
        if (state_reg == S_LOOK)
        begin
            hitv_reg      <= hitv_c;
            age_reg       <= age_c;
            inv_found_reg <= inv_found_c;
            inv_idx_reg   <= inv_idx_c;
        end
    end

endmodule

@@ rtl/core/set_assoc_lru_cache_tag_sim.sv @@
// Flow: addresses wait in the middle queue; launch reads the set row, S_LOOK registers hit
// and age data, S_PICK writes the row back and pushes the result once the result queue has
// room. A new set launches during that write-back; the same set waits for it.
// Reset: counters, stamp clock and per-set row valid bits clear at once; no clearing pass.
// ----------------------------------------------------------------------------
// set_assoc_lru_cache_tag_sim
// Tag store of a set-associative cache with LRU replacement and hit/miss counters.
// ----------------------------------------------------------------------------
module set_assoc_lru_cache_tag_sim import salru_pkg::*; #(
    parameter int MAX_SETS   = MAX_SETS_DEF,
    parameter int MAX_WAYS   = MAX_WAYS_DEF,
    parameter int ADDR_WIDTH = ADDR_WIDTH_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    output logic                  full,
    input  logic [ADDR_WIDTH-1:0] address,
    output logic                  empty,
    input  logic                  pop,
    output logic                  hit,
    output logic                  miss,
    output logic                  evicted,
    output logic [CNT_W-1:0]      hit_total,
    output logic [CNT_W-1:0]      miss_total,
    output logic [CNT_W-1:0]      evict_total,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int SET_W = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
    localparam int EW    = $clog2(MAX_WAYS + 1);
    localparam int MID_W = SET_W + ADDR_WIDTH;

    logic                  mid_push;
    logic                  mid_full;
    logic                  mid_pop;
    logic                  mid_empty;
    logic [SET_W-1:0]      f_set;
    logic [ADDR_WIDTH-1:0] f_tag;
    logic [MID_W-1:0]      mid_rdata;
    logic [EW-1:0]         ways_use;
    logic                  out_push;
    logic                  out_full;
    result_t               out_wdata;
    result_t               out_rdata;

    salru_front #(
        .MAX_SETS   (MAX_SETS),
        .MAX_WAYS   (MAX_WAYS),
        .ADDR_WIDTH (ADDR_WIDTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .address   (address),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_full    (mid_full),
        .q_push    (mid_push),
        .q_set     (f_set),
        .q_tag     (f_tag),
        .ways_use  (ways_use)
    );

    salru_fifo #(
        .WIDTH (MID_W),
        .DEPTH (MID_DEPTH)
    ) u_mid_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (mid_push),
        .wdata ({f_set, f_tag}),
        .full  (mid_full),
        .pop   (mid_pop),
        .rdata (mid_rdata),
        .empty (mid_empty)
    );

    salru_back #(
        .MAX_SETS   (MAX_SETS),
        .MAX_WAYS   (MAX_WAYS),
        .ADDR_WIDTH (ADDR_WIDTH)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_empty  (mid_empty),
        .q_set    (mid_rdata[MID_W-1 -: SET_W]),
        .q_tag    (mid_rdata[ADDR_WIDTH-1:0]),
        .q_pop    (mid_pop),
        .ways_use (ways_use),
        .out_full (out_full),
        .out_push (out_push),
        .out_data (out_wdata)
    );

    salru_fifo #(
        .WIDTH ($bits(result_t)),
        .DEPTH (OUT_DEPTH)
    ) u_out_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (out_push),
        .wdata (out_wdata),
        .full  (out_full),
        .pop   (pop),
        .rdata (out_rdata),
        .empty (empty)
    );

    assign full        = mid_full;
    assign hit         = out_rdata.hit;
    assign miss        = out_rdata.miss;
    assign evicted     = out_rdata.evicted;
    assign hit_total   = out_rdata.hit_total;
    assign miss_total  = out_rdata.miss_total;
    assign evict_total = out_rdata.evict_total;

endmodule

@@ rtl/core/salru_chk.sv @@
// ----------------------------------------------------------------------------
// salru_chk
// Port-level checks of the result stream, bound to the top level.
// ----------------------------------------------------------------------------
module salru_chk import salru_pkg::*; (
    input logic             clk,
    input logic             rst_n,
    input logic             empty,
    input logic             pop,
    input logic             hit,
    input logic             miss,
    input logic             evicted,
    input logic [CNT_W-1:0] hit_total,
    input logic [CNT_W-1:0] miss_total,
    input logic [CNT_W-1:0] evict_total
);

    logic [CNT_W-1:0] last_sum_reg;
    logic [CNT_W-1:0] sum;

    assign sum = hit_total + miss_total;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_sum_reg <= '0;
        end
        else if (pop && !empty)
        begin
            last_sum_reg <= sum;
        end
    end

    a_hit_xor_miss: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (hit != miss))
        else $error("hit and miss not exclusive");

    a_evict_on_miss: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && evicted) |-> miss)
        else $error("eviction reported without a miss");

    a_one_per_beat: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (sum == last_sum_reg + 1'b1))
        else $error("access count does not advance by one per beat");

    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(evict_total) && $stable(sum)))
        else $error("stalled result changed");

endmodule

bind set_assoc_lru_cache_tag_sim salru_chk u_chk (.*);

@@ dv/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Testbench for the set-associative LRU tag simulator.
// Addresses go in through the push/full queue port and results come back
// through the empty/pop port. A local model of the tag store predicts every
// result, and each popped beat is compared field by field with the oldest
// prediction. Directed tests cover the reset settings, duplicate tags left
// over after a reconfiguration, LRU victim order and out-of-range register
// values. Random traffic then draws addresses from one small tag pool in a
// few sets, so hits and evictions are common. It runs under several register
// settings and several sender and receiver idle mixes, and includes a long
// receiver stall that fills the block.
// ----------------------------------------------------------------------------
module tb import salru_pkg::*; ();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LINE_COUNT   = MAX_SETS_DEF * MAX_WAYS_DEF;
    localparam int SET_LIMIT    = $clog2(MAX_SETS_DEF);
    localparam int DRAIN_CYCLES = 8;
    localparam int LIMIT_CYCLES = 200000;
    localparam int CHUNK_ITEMS  = 46;

    logic                      clk       = 1'b0;
    logic                      rst_n     = 1'b0;
    logic                      push      = 1'b0;
    logic                      full;
    logic [ADDR_WIDTH_DEF-1:0] address   = '0;
    logic                      empty;
    logic                      pop       = 1'b0;
    logic                      hit;
    logic                      miss;
    logic                      evicted;
    logic [CNT_W-1:0]          hit_total;
    logic [CNT_W-1:0]          miss_total;
    logic [CNT_W-1:0]          evict_total;
    logic                      cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0]      cfg_index = REG_SET_BITS;
    logic [CFG_DATA_W-1:0]     cfg_data  = '0;

    // register shadow
    logic [SET_BITS_W-1:0]   cfg_set_bits;
    logic [WAYS_W-1:0]       cfg_ways;
    logic [BLOCK_BITS_W-1:0] cfg_block_bits;

    // tag store shadow
    bit                 line_live  [LINE_COUNT];
    logic [31:0]        line_tag_q [LINE_COUNT];
    logic [STAMP_W-1:0] line_stamp [LINE_COUNT];
    logic [STAMP_W-1:0] stamp_clock;
    logic [CNT_W-1:0]   hit_count;
    logic [CNT_W-1:0]   miss_count;
    logic [CNT_W-1:0]   evict_count;

    result_t     pending_results[$];
    result_t     head_result;
    int          error_count   = 0;
    int          cycle_count   = 0;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          hold_cycles   = 0;
    logic [31:0] tag_base      = '0;

    set_assoc_lru_cache_tag_sim dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .address     (address),
        .empty       (empty),
        .pop         (pop),
        .hit         (hit),
        .miss        (miss),
        .evicted     (evicted),
        .hit_total   (hit_total),
        .miss_total  (miss_total),
        .evict_total (evict_total),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("tb NOT OK");
            $finish;
        end
    end

    function automatic int unsigned eff_set_bits();
        return (cfg_set_bits > SET_LIMIT) ? SET_LIMIT : cfg_set_bits;
    endfunction

    function automatic int unsigned eff_ways();
        if (cfg_ways == 0)
            return 1;
        return (cfg_ways > MAX_WAYS_DEF) ? MAX_WAYS_DEF : cfg_ways;
    endfunction

    function automatic void clear_tag_store();
        for (int i = 0; i < LINE_COUNT; i++)
        begin
            line_live[i]  = 1'b0;
            line_tag_q[i] = '0;
            line_stamp[i] = STAMP_INIT;
        end
        stamp_clock    = STAMP_INIT;
        hit_count      = '0;
        miss_count     = '0;
        evict_count    = '0;
        cfg_set_bits   = '0;
        cfg_ways       = 4'd1;
        cfg_block_bits = '0;
    endfunction

    // one access to the tag store shadow
    function automatic result_t cache_access(logic [31:0] a);
        int unsigned s;
        int unsigned e;
        int unsigned b;
        int unsigned tsh;
        int unsigned base;
        int unsigned victim;
        logic [31:0] tg;
        logic [31:0] age;
        logic [31:0] best;
        bit          found;
        bit          matched;
        result_t     r;
        s       = eff_set_bits();
        e       = eff_ways();
        b       = cfg_block_bits;
        tsh     = s + b;
        tg      = (tsh >= 32) ? 32'd0 : (a >> tsh);
        base    = ((a >> b) & ((32'd1 << s) - 32'd1)) * MAX_WAYS_DEF;
        matched = 1'b0;
        found   = 1'b0;
        victim  = 0;
        best    = '0;
        r       = '0;
        stamp_clock = stamp_clock - 1;
        for (int j = 0; j < e; j++)
        begin
            if (line_live[base + j] && line_tag_q[base + j] == tg)
            begin
                line_stamp[base + j] = stamp_clock;
                matched = 1'b1;
            end
        end
        if (matched)
            hit_count = hit_count + 1;
        else
        begin
            miss_count = miss_count + 1;
            for (int j = 0; j < e; j++)
            begin
                if (!found && !line_live[base + j])
                begin
                    victim = j;
                    found  = 1'b1;
                end
            end
            if (!found)
            begin
                for (int j = 0; j < e; j++)
                begin
                    age = line_stamp[base + j] - stamp_clock;
                    if (j == 0 || age > best)
                    begin
                        best   = age;
                        victim = j;
                    end
                end
                r.evicted   = 1'b1;
                evict_count = evict_count + 1;
            end
            line_live[base + victim]  = 1'b1;
            line_tag_q[base + victim] = tg;
            line_stamp[base + victim] = stamp_clock;
        end
        r.hit         = matched;
        r.miss        = !matched;
        r.hit_total   = hit_count;
        r.miss_total  = miss_count;
        r.evict_total = evict_count;
        return r;
    endfunction

    // address from a small tag pool in a few sets, sometimes fully random
    function automatic logic [31:0] pick_address();
        int unsigned s;
        int unsigned b;
        int unsigned tsh;
        logic [63:0] tg;
        logic [63:0] st;
        logic [63:0] off;
        logic [63:0] a;
        s   = eff_set_bits();
        b   = cfg_block_bits;
        tsh = s + b;
        if ($urandom_range(9) < 2)
            return $urandom();
        tg  = 64'(tag_base + $urandom_range(eff_ways() + 1));
        st  = 64'($urandom_range(3)) & ((64'd1 << s) - 64'd1);
        off = 64'($urandom()) & ((64'd1 << b) - 64'd1);
        a   = ((tsh >= 32) ? 64'd0 : (tg << tsh)) | (st << b) | off;
        return a[31:0];
    endfunction

    // result side: check on accepted beats, random pop, long hold-off on request
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (pop && !empty)
            begin
                if (pending_results.size() == 0)
                begin
                    $error("result beat with no expectation pending");
                    error_count++;
                end
                else
                begin
                    head_result = pending_results.pop_front();
                    if (hit !== head_result.hit)
                    begin
                        $error("hit: expected %0h, got %0h", head_result.hit, hit);
                        error_count++;
                    end
                    if (miss !== head_result.miss)
                    begin
                        $error("miss: expected %0h, got %0h", head_result.miss, miss);
                        error_count++;
                    end
                    if (evicted !== head_result.evicted)
                    begin
                        $error("evicted: expected %0h, got %0h", head_result.evicted, evicted);
                        error_count++;
                    end
                    if (hit_total !== head_result.hit_total)
                    begin
                        $error("hit_total: expected %0h, got %0h",
                               head_result.hit_total, hit_total);
                        error_count++;
                    end
                    if (miss_total !== head_result.miss_total)
                    begin
                        $error("miss_total: expected %0h, got %0h",
                               head_result.miss_total, miss_total);
                        error_count++;
                    end
                    if (evict_total !== head_result.evict_total)
                    begin
                        $error("evict_total: expected %0h, got %0h",
                               head_result.evict_total, evict_total);
                        error_count++;
                    end
                end
            end
            if (hold_cycles > 0)
            begin
                hold_cycles <= hold_cycles - 1;
                pop <= 1'b0;
            end
            else
                pop <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // push stays high after an accepted beat; an idle draw or drain_results drops it
    task automatic send_address(input logic [31:0] a);
        while ($urandom_range(99) < send_idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push    <= 1'b1;
        address <= a;
        @(posedge clk);
        while (full)
            @(posedge clk);
        pending_results.push_back(cache_access(a));
    endtask

    task automatic drain_results();
        push <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] v);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        @(posedge clk);
        cfg_write <= 1'b0;
        case (idx)
            REG_SET_BITS:   cfg_set_bits   = v[SET_BITS_W-1:0];
            REG_WAYS:       cfg_ways       = v[WAYS_W-1:0];
            REG_BLOCK_BITS: cfg_block_bits = v[BLOCK_BITS_W-1:0];
            default:        ;
        endcase
        @(posedge clk);
    endtask

    task automatic set_config(input int unsigned sb, input int unsigned wy, input int unsigned bb);
        drain_results();
        write_reg(REG_SET_BITS, CFG_DATA_W'(sb));
        write_reg(REG_WAYS, CFG_DATA_W'(wy));
        write_reg(REG_BLOCK_BITS, CFG_DATA_W'(bb));
    endtask

    task automatic test_reset_settings();
        send_address(32'h0000_0000);
        send_address(32'h0000_0000);
        send_address(32'hffff_ffff);
        send_address(32'hffff_ffff);
        send_address(32'h0000_0001);
    endtask

    // same tag left in two ways after shrinking and regrowing the way count
    task automatic test_duplicate_tags();
        set_config(0, 2, 0);
        send_address(32'd1);
        send_address(32'd2);
        drain_results();
        write_reg(REG_WAYS, 5'd1);
        send_address(32'd2);
        drain_results();
        write_reg(REG_WAYS, 5'd2);
        send_address(32'd2);
        send_address(32'd3);
        send_address(32'd2);
    endtask

    task automatic test_lru_order();
        set_config(0, 4, 2);
        send_address(32'h100);
        send_address(32'h200);
        send_address(32'h300);
        send_address(32'h400);
        send_address(32'h104);
        send_address(32'h500);
    endtask

    // saturated set bits, out-of-range ways, tag shifted out entirely
    task automatic test_register_extremes();
        set_config(7, 15, 31);
        send_address(32'h0000_0000);
        send_address(32'hffff_ffff);
        send_address(32'h8000_0000);
        set_config(6, 0, 26);
        send_address(32'hfc00_0000);
        send_address(32'h03ff_ffff);
        send_address(32'h0400_0000);
    endtask

    task automatic test_random_traffic(input int sidle, input int ridle, input int chunks);
        int unsigned ways_pick;
        int unsigned block_pick;
        for (int c = 0; c < chunks; c++)
        begin
            case ($urandom_range(5))
                0:       ways_pick = 0;
                1:       ways_pick = $urandom_range(15);
                2:       ways_pick = MAX_WAYS_DEF;
                default: ways_pick = $urandom_range(1, 4);
            endcase
            block_pick = ($urandom_range(9) < 7) ? $urandom_range(6) : $urandom_range(31);
            set_config($urandom_range(7), ways_pick, block_pick);
            send_idle_pct = sidle;
            recv_idle_pct = ridle;
            tag_base      = $urandom();
            for (int i = 0; i < CHUNK_ITEMS; i++)
                send_address(pick_address());
        end
    endtask

    // receiver stalls long enough for the block to fill and hold off the sender
    task automatic test_backpressure();
        set_config(2, 4, 3);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        tag_base      = $urandom();
        hold_cycles   = 300;
        for (int i = 0; i < 30; i++)
            send_address(pick_address());
        drain_results();
    endtask

    initial
    begin
        clear_tag_store();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_settings();
        test_duplicate_tags();
        test_lru_order();
        test_register_extremes();
        test_random_traffic(30, 68, 4);
        test_backpressure();
        test_random_traffic(68, 30, 4);
        test_random_traffic(0, 0, 4);
        drain_results();
        if (error_count == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule
